// ----- hw/rtl/dlt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlt_pkg
// Shared types and constants of the delta instruction decoder.
// ---------------------------------------------------------------------------
package dlt_pkg;

	// Width of offsets, lengths and counters inside the decoder
	localparam int LEN_BITS  = 32;
	// Width of the length fields at the ports and of the register bus
	localparam int PORT_BITS = 32;
	localparam int ADDR_BITS = 4;

	typedef logic [LEN_BITS-1:0]  len_t;
	typedef logic [PORT_BITS-1:0] word_t;
	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_OFFSET = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SOURCE = 2'd0,
		KIND_TARGET = 2'd1,
		KIND_NEW    = 2'd2,
		KIND_BAD    = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_TRUNCATED    = 4'd1,
		ST_OVERFLOW     = 4'd2,
		ST_BAD_KIND     = 4'd3,
		ST_SOURCE       = 4'd4,
		ST_TARGET       = 4'd5,
		ST_NEW_OVERRUN  = 4'd6,
		ST_LEN_MISMATCH = 4'd7,
		ST_NEW_LEFTOVER = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		REG_SOURCE_LENGTH   = 2'd0,
		REG_TARGET_LENGTH   = 2'd1,
		REG_NEW_DATA_LENGTH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		len_t source_length;
		len_t target_length;
		len_t new_data_length;
	} cfg_t;

	typedef struct packed {
		logic    instruction_valid;
		kind_t   copy_kind;
		word_t   copy_offset;
		word_t   copy_length;
		status_t status;
		logic    window_done;
	} result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dlt_apb_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlt_apb_regs
// APB register file holding the window lengths.
// ---------------------------------------------------------------------------
module dlt_apb_regs (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire dlt_pkg::addr_t paddr,
	input  wire dlt_pkg::word_t pwdata,
	output dlt_pkg::word_t      prdata,
	output logic                pready,
	output dlt_pkg::cfg_t       cfg
);
	import dlt_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_SOURCE_LENGTH:   cfg_q.source_length   <= LEN_BITS'(pwdata);
				REG_TARGET_LENGTH:   cfg_q.target_length   <= LEN_BITS'(pwdata);
				REG_NEW_DATA_LENGTH: cfg_q.new_data_length <= LEN_BITS'(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SOURCE_LENGTH:   prdata = PORT_BITS'(cfg_q.source_length);
			REG_TARGET_LENGTH:   prdata = PORT_BITS'(cfg_q.target_length);
			REG_NEW_DATA_LENGTH: prdata = PORT_BITS'(cfg_q.new_data_length);
			default:             prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dlt_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlt_decode
// Input register, window state and single-pass instruction decode/check.
// ---------------------------------------------------------------------------
module dlt_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dlt_pkg::cfg_t cfg,
	input  wire logic          item_valid,
	output logic               item_ready,
	input  wire logic [7:0]    instruction_byte,
	input  wire logic          section_end,
	input  wire logic          out_free,
	output logic               res_we,
	output dlt_pkg::result_t   res
);
	import dlt_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// window state
	phase_t  phase_q, phase_n;
	len_t    acc_q, acc_n;
	kind_t   pkind_q, pkind_n;
	len_t    plen_q, plen_n;
	len_t    bw_q, bw_n;
	len_t    ndu_q, ndu_n;
	logic    ndu_ovf_q, ndu_ovf_n;  // new data used went past LEN_BITS
	logic    err_q, err_n;
	status_t ferr_q, ferr_n;

	logic              advance;
	logic              done;
	logic              valid;
	logic              emit;
	logic              ndu_over;
	len_t              off;
	status_t           code;
	status_t           end_code;
	logic [LEN_BITS:0] bw_sum;
	logic [LEN_BITS:0] ndu_sum;

	assign advance    = valid_s1 && out_free;
	assign item_ready = !valid_s1 || out_free;
	assign ndu_over   = ndu_ovf_q || (ndu_q > cfg.new_data_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			byte_s1 <= instruction_byte;
			end_s1  <= section_end;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		pkind_n   = pkind_q;
		plen_n    = plen_q;
		bw_n      = bw_q;
		ndu_n     = ndu_q;
		ndu_ovf_n = ndu_ovf_q;
		err_n     = err_q;
		ferr_n    = ferr_q;
		done      = 1'b0;
		valid     = 1'b0;
		emit      = 1'b0;
		off       = '0;
		code      = ST_OK;
		end_code  = ST_OK;
		bw_sum    = '0;
		ndu_sum   = '0;

		if (!err_q) begin
			if (phase_q != PH_HEADER) begin
				// another 7 bits would push the top group out
				if (acc_q[LEN_BITS-1 -: 7] != '0) begin
					code = ST_OVERFLOW;
				end else begin
					acc_n = {acc_q[LEN_BITS-8:0], byte_s1[6:0]};
					if (!byte_s1[7]) begin
						if (phase_q == PH_LENGTH) begin
							plen_n = acc_n;
							acc_n  = '0;
							if (pkind_q == KIND_SOURCE || pkind_q == KIND_TARGET) begin
								phase_n = PH_OFFSET;
							end else begin
								done = 1'b1;
							end
						end else begin
							off  = acc_n;
							done = 1'b1;
						end
					end
				end
			end else begin
				pkind_n = kind_t'(byte_s1[7:6]);
				acc_n   = '0;
				if (byte_s1[5:0] == 6'd0) begin
					phase_n = PH_LENGTH;
				end else begin
					plen_n = LEN_BITS'(byte_s1[5:0]);
					if (pkind_n == KIND_SOURCE || pkind_n == KIND_TARGET) begin
						phase_n = PH_OFFSET;
					end else begin
						done = 1'b1;
					end
				end
			end

			if (done) begin
				phase_n = PH_HEADER;
				acc_n   = '0;
				unique case (pkind_n)
					KIND_SOURCE: begin
						if (off > cfg.source_length || plen_n > cfg.source_length - off) begin
							code = ST_SOURCE;
						end
					end
					KIND_TARGET: begin
						if (off >= bw_q || plen_n == '0) begin
							code = ST_TARGET;
						end
					end
					KIND_NEW: begin
						if (!ndu_over && plen_n > cfg.new_data_length - ndu_q) begin
							code = ST_NEW_OVERRUN;
						end
					end
					KIND_BAD: code = ST_BAD_KIND;
					default:  code = ST_BAD_KIND;
				endcase
				if (code == ST_OK) begin
					valid = 1'b1;
					emit  = 1'b1;
					if (pkind_n == KIND_NEW) begin
						ndu_sum   = {1'b0, ndu_q} + {1'b0, plen_n};
						ndu_n     = ndu_sum[LEN_BITS-1:0];
						ndu_ovf_n = ndu_ovf_q || ndu_sum[LEN_BITS];
					end
					// written count saturates
					bw_sum = {1'b0, bw_q} + {1'b0, plen_n};
					bw_n   = bw_sum[LEN_BITS] ? '1 : bw_sum[LEN_BITS-1:0];
				end
			end

			if (code != ST_OK) begin
				err_n  = 1'b1;
				ferr_n = code;
				emit   = 1'b1;
			end
		end

		if (phase_n != PH_HEADER) begin
			end_code = ST_TRUNCATED;
		end else if (bw_n != cfg.target_length) begin
			end_code = ST_LEN_MISMATCH;
		end else if (ndu_ovf_n || ndu_n != cfg.new_data_length) begin
			end_code = ST_NEW_LEFTOVER;
		end

		res.instruction_valid = valid;
		res.copy_kind         = valid ? pkind_n : KIND_SOURCE;
		res.copy_offset       = valid ? PORT_BITS'(off) : '0;
		res.copy_length       = valid ? PORT_BITS'(plen_n) : '0;
		res.status            = code;
		res.window_done       = end_s1;

		if (end_s1) begin
			emit       = 1'b1;
			res.status = err_n ? ferr_n : end_code;
			phase_n    = PH_HEADER;
			acc_n      = '0;
			pkind_n    = KIND_SOURCE;
			plen_n     = '0;
			bw_n       = '0;
			ndu_n      = '0;
			ndu_ovf_n  = 1'b0;
			err_n      = 1'b0;
			ferr_n     = ST_OK;
		end
	end

	assign res_we = advance && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			acc_q     <= '0;
			pkind_q   <= KIND_SOURCE;
			plen_q    <= '0;
			bw_q      <= '0;
			ndu_q     <= '0;
			ndu_ovf_q <= 1'b0;
			err_q     <= 1'b0;
			ferr_q    <= ST_OK;
		end else if (advance) begin
			phase_q   <= phase_n;
			acc_q     <= acc_n;
			pkind_q   <= pkind_n;
			plen_q    <= plen_n;
			bw_q      <= bw_n;
			ndu_q     <= ndu_n;
			ndu_ovf_q <= ndu_ovf_n;
			err_q     <= err_n;
			ferr_q    <= ferr_n;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dlt_result_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlt_result_reg
// Result register between the decode stage and the output channel.
// ---------------------------------------------------------------------------
module dlt_result_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_we,
	input  wire dlt_pkg::result_t res,
	output logic                  out_free,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output dlt_pkg::result_t      result
);
	import dlt_pkg::*;

	logic    valid_q;
	result_t res_q;

	// slot frees in the same cycle the held item leaves
	assign out_free     = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_we) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/delta_instruction_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// delta_instruction_decoder
// Decodes and checks the instruction section of a delta window, one byte per item.
// ---------------------------------------------------------------------------
// Takes one instruction byte per cycle while the input is not stalled: each
// accepted byte is captured in the input register, decoded and checked there
// in a single pass, and any result is written into the output register when
// it is free; input stalls only behind an untaken result in that register.
// Bytes that neither complete an instruction, raise an error nor close the
// section produce no result. The user must write lengths over APB at 0x0
// (source), 0x4 (target), 0x8 (new data) between sections, unchecked by the block.
module delta_instruction_decoder (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire dlt_pkg::addr_t paddr,
	input  wire dlt_pkg::word_t pwdata,
	output dlt_pkg::word_t      prdata,
	output logic                pready,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire logic [7:0]     instruction_byte,
	input  wire logic           section_end,
	output logic                result_valid,
	input  wire logic           result_ready,
	output logic                instruction_valid,
	output logic [1:0]          copy_kind,
	output dlt_pkg::word_t      copy_offset,
	output dlt_pkg::word_t      copy_length,
	output logic [3:0]          status,
	output logic                window_done
);
	import dlt_pkg::*;

	cfg_t    cfg;
	logic    out_free;
	logic    res_we;
	result_t res;
	result_t result;

	dlt_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dlt_decode u_decode (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.instruction_byte (instruction_byte),
		.section_end      (section_end),
		.out_free         (out_free),
		.res_we           (res_we),
		.res              (res)
	);

	dlt_result_reg u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_we       (res_we),
		.res          (res),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	assign instruction_valid = result.instruction_valid;
	assign copy_kind         = result.copy_kind;
	assign copy_offset       = result.copy_offset;
	assign copy_length       = result.copy_length;
	assign status            = result.status;
	assign window_done       = result.window_done;

	// rejected or absent instructions carry zero fields
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !instruction_valid |->
			copy_kind == 2'd0 && copy_offset == '0 && copy_length == '0)
		else $error("non-instruction result carries fields");

	// a reported instruction mid-section is always clean
	a_valid_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && instruction_valid && !window_done |-> status == ST_OK)
		else $error("instruction reported with error status");

	// input only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("input stalled without a held result");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for delta_instruction_decoder. Bytes of instruction
// sections are streamed with random gaps, every result is compared field by
// field against a cycle-free decoder model, and window lengths are
// reprogrammed over APB between sections.
// ---------------------------------------------------------------------------
module tb;
	import dlt_pkg::*;

	localparam int    RANDOM_ITEMS = 1550;
	localparam int    DRAIN_CYCLES = 8;
	localparam int    STALL_LIMIT  = 2000;
	localparam len_t  LEN_MAX      = '1;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       psel = 1'b0;
	logic       penable = 1'b0;
	logic       pwrite = 1'b0;
	addr_t      paddr = '0;
	word_t      pwdata = '0;
	word_t      prdata;
	logic       pready;
	logic       item_valid = 1'b0;
	logic       item_ready;
	logic [7:0] instruction_byte = 8'h00;
	logic       section_end = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic       instruction_valid;
	logic [1:0] copy_kind;
	word_t      copy_offset;
	word_t      copy_length;
	logic [3:0] status;
	logic       window_done;

	delta_instruction_decoder dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.item_valid        (item_valid),
		.item_ready        (item_ready),
		.instruction_byte  (instruction_byte),
		.section_end       (section_end),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.instruction_valid (instruction_valid),
		.copy_kind         (copy_kind),
		.copy_offset       (copy_offset),
		.copy_length       (copy_length),
		.status            (status),
		.window_done       (window_done)
	);

	always #5 clk = ~clk;

	// Decoder model state
	len_t    cfg_src = '0;
	len_t    cfg_tgt = '0;
	len_t    cfg_new = '0;
	phase_t  dec_phase = PH_HEADER;
	len_t    vacc = '0;
	kind_t   pend_kind = KIND_SOURCE;
	len_t    pend_len = '0;
	len_t    written = '0;
	len_t    new_used = '0;
	logic    err_seen = 1'b0;
	status_t first_err = ST_OK;

	result_t    expected_results[$];
	byte_item_t pending_items[$];
	byte_item_t window_bytes[$];
	byte_item_t nxt;
	result_t    want;

	int bytes_queued = 0;
	int bytes_accepted = 0;
	int results_seen = 0;
	int instr_seen = 0;
	int windows_closed = 0;
	int failures = 0;
	int gap_left = 0;
	int burst_left = 0;
	int ready_left = 0;
	int idle_cycles = 0;

	function automatic status_t check_instr(kind_t k, len_t off, len_t len);
		case (k)
			KIND_SOURCE: begin
				if (off > cfg_src || len > cfg_src - off)
					return ST_SOURCE;
			end
			KIND_TARGET: begin
				if (off >= written || len == 0)
					return ST_TARGET;
			end
			KIND_NEW: begin
				if (len > cfg_new - new_used)
					return ST_NEW_OVERRUN;
				new_used = new_used + len;
			end
			default: return ST_BAD_KIND;
		endcase
		written = (len > LEN_MAX - written) ? LEN_MAX : written + len;
		return ST_OK;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic last);
		result_t r;
		status_t code;
		logic    emit;
		logic    done;
		len_t    off;
		r = '0;
		code = ST_OK;
		emit = 1'b0;
		done = 1'b0;
		off = '0;
		if (!err_seen) begin
			if (dec_phase != PH_HEADER) begin
				if (vacc > (LEN_MAX >> 7)) begin
					code = ST_OVERFLOW;
				end else begin
					vacc = (vacc << 7) | len_t'(b[6:0]);
					if (!b[7]) begin
						if (dec_phase == PH_LENGTH) begin
							pend_len = vacc;
							vacc = '0;
							if (pend_kind == KIND_SOURCE || pend_kind == KIND_TARGET)
								dec_phase = PH_OFFSET;
							else
								done = 1'b1;
						end else begin
							off = vacc;
							done = 1'b1;
						end
					end
				end
			end else begin
				pend_kind = kind_t'(b[7:6]);
				vacc = '0;
				if (b[5:0] == 6'd0) begin
					dec_phase = PH_LENGTH;
				end else begin
					pend_len = len_t'(b[5:0]);
					if (pend_kind == KIND_SOURCE || pend_kind == KIND_TARGET)
						dec_phase = PH_OFFSET;
					else
						done = 1'b1;
				end
			end
			if (done) begin
				dec_phase = PH_HEADER;
				vacc = '0;
				code = check_instr(pend_kind, off, pend_len);
				if (code == ST_OK) begin
					r.instruction_valid = 1'b1;
					r.copy_kind = pend_kind;
					r.copy_offset = off;
					r.copy_length = pend_len;
					emit = 1'b1;
				end
			end
			if (code != ST_OK) begin
				err_seen = 1'b1;
				first_err = code;
				r.status = code;
				emit = 1'b1;
			end
		end
		if (last) begin
			emit = 1'b1;
			r.window_done = 1'b1;
			if (err_seen)
				r.status = first_err;
			else if (dec_phase != PH_HEADER)
				r.status = ST_TRUNCATED;
			else if (written != cfg_tgt)
				r.status = ST_LEN_MISMATCH;
			else if (new_used != cfg_new)
				r.status = ST_NEW_LEFTOVER;
			else
				r.status = ST_OK;
			// window state returns to reset, lengths are kept
			dec_phase = PH_HEADER;
			vacc = '0;
			pend_kind = KIND_SOURCE;
			pend_len = '0;
			written = '0;
			new_used = '0;
			err_seen = 1'b0;
			first_err = ST_OK;
		end
		if (emit)
			expected_results.push_back(r);
	endtask

	// Byte sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				decode_byte(instruction_byte, section_end);
				bytes_accepted++;
			end
			if (!item_valid || item_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					nxt = pending_items.pop_front();
					instruction_byte <= nxt.data;
					section_end <= nxt.last;
					item_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: ready and stall runs of random length
	always @(posedge clk) begin
		if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else begin
			result_ready <= ($urandom_range(0, 2) != 0);
			ready_left <= $urandom_range(0, 24);
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (act !== exp) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d, window_done %0b", status, window_done);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (want.instruction_valid)
					instr_seen++;
				if (want.window_done)
					windows_closed++;
				check_field("instruction_valid", 32'(want.instruction_valid),
					32'(instruction_valid));
				check_field("copy_kind", 32'(want.copy_kind), 32'(copy_kind));
				check_field("copy_offset", want.copy_offset, copy_offset);
				check_field("copy_length", want.copy_length, copy_length);
				check_field("status", 32'(want.status), 32'(status));
				check_field("window_done", 32'(want.window_done), 32'(window_done));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no progress for %0d cycles, %0d results outstanding",
				idle_cycles, expected_results.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic apb_write(input reg_idx_t idx, input word_t val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SOURCE_LENGTH:   cfg_src = val;
			REG_TARGET_LENGTH:   cfg_tgt = val;
			REG_NEW_DATA_LENGTH: cfg_new = val;
			default: ;
		endcase
	endtask

	task automatic set_lengths(input len_t src, input len_t tgt, input len_t nd);
		apb_write(REG_SOURCE_LENGTH, src);
		apb_write(REG_TARGET_LENGTH, tgt);
		apb_write(REG_NEW_DATA_LENGTH, nd);
	endtask

	task automatic send(input logic [7:0] b, input logic last);
		byte_item_t it;
		it.data = b;
		it.last = last;
		pending_items.push_back(it);
		bytes_queued++;
	endtask

	// Sender holds off until every queued byte is in and every result is back
	task automatic drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic put_byte(input logic [7:0] b);
		byte_item_t it;
		it.data = b;
		it.last = 1'b0;
		window_bytes.push_back(it);
	endtask

	// MSB-first 7-bit groups, sometimes with a leading zero group
	task automatic push_varint(input logic [63:0] v);
		logic [6:0] groups[$];
		do begin
			groups.push_front(v[6:0]);
			v = v >> 7;
		end while (v != 0);
		if ($urandom_range(0, 9) == 0)
			groups.push_front(7'd0);
		foreach (groups[i])
			put_byte({i != groups.size() - 1, groups[i]});
	endtask

	task automatic put_instr(input kind_t k, input logic [63:0] len, input logic [63:0] off);
		if (len >= 1 && len <= 63 && $urandom_range(0, 3) != 0) begin
			put_byte({k, len[5:0]});
		end else begin
			put_byte({k, 6'd0});
			push_varint(len);
		end
		if (k == KIND_SOURCE || k == KIND_TARGET)
			push_varint(off);
	endtask

	function automatic longint unsigned rand_upto(longint unsigned x);
		if (x <= 200)
			return 64'($urandom_range(0, int'(x)));
		if ($urandom_range(0, 1) == 0)
			return 64'($urandom_range(0, 200));
		return {$urandom, $urandom} % (x + 1);
	endfunction

	function automatic longint unsigned capped_sum(longint unsigned a, longint unsigned b);
		return (a + b > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a + b;
	endfunction

	// Mostly well-formed sections whose lengths match, plus injected faults
	task automatic random_window();
		longint unsigned src, wr, used, off, len, tgt, nd;
		int n_instr, pick, instr_start;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			src = 0;
		else if (pick == 1)
			src = 64'hFFFF_FFFF;
		else if (pick == 2)
			src = 64'($urandom);
		else
			src = 64'($urandom_range(0, 300));
		window_bytes.delete();
		wr = 0;
		used = 0;
		instr_start = 0;
		n_instr = $urandom_range(0, 7);
		for (int i = 0; i < n_instr; i++) begin
			instr_start = window_bytes.size();
			pick = $urandom_range(0, 99);
			if (pick < 35 || (pick < 60 && wr == 0)) begin
				off = rand_upto(src);
				len = rand_upto(src - off);
				if ($urandom_range(0, 19) == 0)
					len = src - off + 1;
				else
					wr = capped_sum(wr, len);
				put_instr(KIND_SOURCE, len, off);
			end else if (pick < 60) begin
				off = rand_upto(wr - 1);
				len = 64'($urandom_range(1, 90));
				pick = $urandom_range(0, 39);
				if (pick == 0)
					len = 0;
				else if (pick == 1)
					off = wr;
				else
					wr = capped_sum(wr, len);
				put_instr(KIND_TARGET, len, off);
			end else if (pick < 92) begin
				len = 64'($urandom_range(0, 90));
				used += len;
				wr = capped_sum(wr, len);
				put_instr(KIND_NEW, len, 64'd0);
			end else begin
				pick = $urandom_range(0, 3);
				if (pick < 2) begin
					put_byte(8'($urandom_range(0, 255)));
				end else if (pick == 2) begin
					put_instr(KIND_BAD, 64'($urandom_range(0, 100)), 64'd0);
				end else begin
					// length varint too wide for the counters
					put_byte({2'($urandom_range(0, 3)), 6'd0});
					put_byte(8'hFF);
					repeat (3) put_byte(8'h80 | 8'($urandom_range(0, 127)));
					put_byte(8'($urandom_range(0, 255)));
				end
			end
		end
		if (window_bytes.size() == 0)
			put_byte(8'($urandom_range(0, 255)));
		else if ($urandom_range(0, 15) == 0 && window_bytes.size() - instr_start > 1)
			void'(window_bytes.pop_back());
		window_bytes[window_bytes.size() - 1].last = 1'b1;

		tgt = wr;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			tgt = capped_sum(wr, 64'($urandom_range(1, 5)));
		else if (pick == 1)
			tgt = 64'($urandom);
		else if (pick == 2)
			tgt = 0;
		nd = used;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			nd = used + 64'($urandom_range(1, 9));
		else if (pick == 1)
			nd = 64'($urandom);
		else if (pick == 2 && used != 0)
			nd = used - 1;

		set_lengths(len_t'(src), len_t'(tgt), len_t'(nd));
		// same section twice in a row: lengths still match the second time
		repeat (($urandom_range(0, 9) < 3) ? 2 : 1)
			foreach (window_bytes[j])
				send(window_bytes[j].data, window_bytes[j].last);
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// all three kinds, full-width varint, written count saturates, ends on an instruction
		set_lengths('1, '1, 32'd5);
		send({KIND_SOURCE, 6'd0}, 1'b0);
		send(8'h8F, 1'b0);
		send(8'hFF, 1'b0);
		send(8'hFF, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h7F, 1'b0);
		send(8'h00, 1'b0);
		send({KIND_TARGET, 6'd3}, 1'b0);
		send(8'h7F, 1'b0);
		send({KIND_NEW, 6'd5}, 1'b1);
		drain();

		// bad kind with a sticky error, varint overflow, truncated section
		set_lengths('0, '0, '0);
		send({KIND_BAD, 6'd1}, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h00, 1'b1);
		send({KIND_NEW, 6'd0}, 1'b0);
		repeat (4) send(8'hFF, 1'b0);
		send(8'hFF, 1'b1);
		send({KIND_SOURCE, 6'd0}, 1'b1);
		drain();

		// source range, target offset, new overrun, length mismatch
		set_lengths(32'd2, 32'd2, '0);
		send({KIND_SOURCE, 6'd2}, 1'b0);
		send(8'h01, 1'b1);
		send({KIND_TARGET, 6'd1}, 1'b0);
		send(8'h00, 1'b1);
		send({KIND_NEW, 6'd1}, 1'b1);
		send({KIND_SOURCE, 6'd1}, 1'b0);
		send(8'h00, 1'b1);
		drain();

		// new data left over
		set_lengths('0, 32'd1, 32'd7);
		send({KIND_NEW, 6'd1}, 1'b1);
		drain();

		while (bytes_queued < RANDOM_ITEMS + 28)
			random_window();
		drain();

		$display("Streamed %0d instruction bytes; %0d results checked (%0d instructions, %0d sections closed).",
			bytes_accepted, results_seen, instr_seen, windows_closed);
		$display("Section lengths were reprogrammed between sections, zero and all-ones included.");
		if (failures == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
